[rtl/hte_pkg.sv]
`timescale 1ns / 1ps
// hte_pkg: types and constants shared by the HTML escape/truncate block.
// No dependencies; imported by html_escape_truncate, hte_front, hte_fifo, hte_back.
`default_nettype none

package hte_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_CODE = 8'h80;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_D2    = 8'h32;
	localparam logic [7:0] CH_D3    = 8'h33;
	localparam logic [7:0] CH_D4    = 8'h34;
	localparam logic [7:0] CH_D6    = 8'h36;
	localparam logic [7:0] CH_D8    = 8'h38;
	localparam logic [7:0] CH_D9    = 8'h39;
	localparam logic [7:0] CH_D0    = 8'h30;

	// What the back end has to emit for one accepted input beat.
	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_ENT,
		KIND_DOTS,
		KIND_MARK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/html_escape_truncate.sv]
`timescale 1ns / 1ps
// html_escape_truncate: top level of the HTML escape and UTF-8 truncate block.
// Instantiates hte_front, hte_fifo and hte_back; depends on hte_pkg.
// The block takes one input beat per cycle while its four-entry command queue
// has room. Each beat that yields output becomes one command; the back end
// turns a command into 1 beat (plain byte or end marker), 3 beats (ellipsis)
// or 5 beats (numeric entity) at one beat per cycle, so output throughput is
// set by that serializer and input stalls only when expansions or output
// stalls keep it busy long enough to fill the queue. Accepted bytes pass the
// queue, command register and output register. max_chars resets to 255 and
// counts characters (bytes other than UTF-8 continuation bytes); the counter
// is COUNT_BITS wide and saturates, so a limit above its range never cuts.
`default_nettype none

module html_escape_truncate #(
	parameter int COUNT_BITS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       string_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            string_end
);
	import hte_pkg::*;

	cmd_t push_data;
	cmd_t pop_data;
	logic push;
	logic full;
	logic pop;
	logic nonempty;

	hte_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.string_last(string_last),
		.q_full     (full),
		.q_push     (push),
		.q_data     (push_data)
	);

	hte_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.nonempty (nonempty)
	);

	hte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(nonempty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.run_last  (run_last),
		.string_end(string_end)
	);

endmodule

`default_nettype wire

[rtl/hte_front.sv]
`timescale 1ns / 1ps
// hte_front: accepts input beats, tracks character count and cut state,
// and turns each beat into at most one command. Depends on hte_pkg.
`default_nettype none

module hte_front #(
	parameter int COUNT_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    in_byte,
	input  wire logic          string_last,
	input  wire logic          q_full,
	output logic               q_push,
	output hte_pkg::cmd_t      q_data
);
	import hte_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [7:0]            max_chars_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  cut_q;

	logic accept;
	logic drop;
	logic starts_char;
	logic active;
	logic at_limit;
	logic do_cut;
	logic escape;

	assign in_stall    = q_full;
	assign accept      = in_valid && !q_full;
	assign drop        = (in_byte < CH_SPACE) || (in_byte == CH_DEL);
	assign starts_char = (in_byte & CONT_MASK) != CONT_CODE;
	assign active      = !cut_q && !drop;
	assign at_limit    = CMP_W'(count_q) == CMP_W'(max_chars_q);
	assign do_cut      = active && starts_char && at_limit;
	assign escape      = (in_byte == CH_AMP) || (in_byte == CH_LT) || (in_byte == CH_GT)
		|| (in_byte == CH_QUOT) || (in_byte == CH_APOS);

	always_comb begin
		q_data.data = in_byte;
		q_data.last = string_last;
		q_push      = accept;
		if (do_cut) begin
			q_data.kind = KIND_DOTS;
		end else if (active && escape) begin
			q_data.kind = KIND_ENT;
		end else if (active) begin
			q_data.kind = KIND_BYTE;
		end else begin
			// nothing to emit: only a final beat leaves an end marker
			q_data.kind = KIND_MARK;
			q_push      = accept && string_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= 8'hFF;
			count_q     <= '0;
			cut_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_chars_q <= cfg_wdata;
			end
			if (accept) begin
				if (string_last) begin
					count_q <= '0;
					cut_q   <= 1'b0;
				end else if (do_cut) begin
					cut_q <= 1'b1;
				end else if (active && starts_char && count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/hte_fifo.sv]
`timescale 1ns / 1ps
// hte_fifo: short command queue between front and back end.
// Depends on hte_pkg for the command type and depth.
`default_nettype none

module hte_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hte_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output hte_pkg::cmd_t      pop_data,
	output logic               nonempty
);
	import hte_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   fill_q;

	assign full     = fill_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign nonempty = fill_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/hte_back.sv]
`timescale 1ns / 1ps
// hte_back: expands queued commands into output beats, one per cycle while
// the output is not stalled, through a registered output stage. Depends on hte_pkg.
`default_nettype none

module hte_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_nonempty,
	input  wire hte_pkg::cmd_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               string_end
);
	import hte_pkg::*;

	cmd_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       byte_valid_q;
	logic       run_last_q;
	logic       string_end_q;

	logic [7:0] gen_byte;
	logic       gen_valid;
	logic [2:0] last_idx;
	logic [7:0] dig_hi;
	logic [7:0] dig_lo;
	logic       is_last;
	logic       out_load;
	logic       advance;
	logic       cur_done;

	always_comb begin
		case (cur_q.data)
			CH_AMP:  begin dig_hi = CH_D3; dig_lo = CH_D8; end
			CH_LT:   begin dig_hi = CH_D6; dig_lo = CH_D0; end
			CH_GT:   begin dig_hi = CH_D6; dig_lo = CH_D2; end
			CH_QUOT: begin dig_hi = CH_D3; dig_lo = CH_D4; end
			default: begin dig_hi = CH_D3; dig_lo = CH_D9; end
		endcase
	end

	always_comb begin
		gen_valid = 1'b1;
		case (cur_q.kind)
			KIND_BYTE: begin
				gen_byte = cur_q.data;
				last_idx = 3'd0;
			end
			KIND_ENT: begin
				last_idx = 3'd4;
				case (idx_q)
					3'd0:    gen_byte = CH_AMP;
					3'd1:    gen_byte = CH_HASH;
					3'd2:    gen_byte = dig_hi;
					3'd3:    gen_byte = dig_lo;
					default: gen_byte = CH_SEMI;
				endcase
			end
			KIND_DOTS: begin
				gen_byte = CH_DOT;
				last_idx = 3'd2;
			end
			default: begin
				gen_byte  = 8'h00;
				gen_valid = 1'b0;
				last_idx  = 3'd0;
			end
		endcase
	end

	assign is_last  = idx_q == last_idx;
	assign out_load = !out_valid_q || !out_stall;
	assign advance  = cur_valid_q && out_load;
	assign cur_done = advance && is_last;
	assign q_pop    = q_nonempty && (!cur_valid_q || cur_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= cur_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_byte_q   <= gen_byte;
			byte_valid_q <= gen_valid;
			run_last_q   <= is_last;
			string_end_q <= is_last && cur_q.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

endmodule

`default_nettype wire

[rtl/hte_checker.sv]
`timescale 1ns / 1ps
// hte_checker: port-level checks for html_escape_truncate, bound to the top.
// No package dependency.
`default_nettype none

module hte_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic       run_last,
	input wire logic       string_end
);

	// a stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(byte_valid) && $stable(run_last) && $stable(string_end))
		else $error("stalled output beat changed");

	// end marker shape
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'h00 && run_last && string_end)
		else $error("malformed end marker");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && string_end |-> run_last)
		else $error("string end without run end");

	// control bytes never leave the block
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> out_byte >= 8'h20 && out_byte != 8'h7F)
		else $error("control byte on output");

endmodule

bind html_escape_truncate hte_checker u_hte_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.byte_valid(byte_valid),
	.run_last  (run_last),
	.string_end(string_end)
);

`default_nettype wire
